// File: src/pbfe_pkg.sv
// ---------------------------------------------------------------------------
// pbfe_pkg
// Shared types and codes for the protocol-buffer field encoder.
// ---------------------------------------------------------------------------
package pbfe_pkg;

  localparam int FNUM_W  = 29;
  localparam int MODE_W  = 3;
  localparam int VALUE_W = 64;
  localparam int TAG_W   = FNUM_W + 3;
  localparam int IN_W    = FNUM_W + MODE_W + VALUE_W;
  localparam int CNT_W   = 4;

  localparam logic [MODE_W-1:0] MODE_VARINT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ZIGZAG32 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ZIGZAG64 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIXED32  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIXED64  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LENGTH   = 3'd5;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_I64    = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_I32    = 3'd5;

  localparam logic [CNT_W-1:0] FIXED32_BYTES = 4'd4;
  localparam logic [CNT_W-1:0] FIXED64_BYTES = 4'd8;

  typedef struct packed {
    logic load;
    logic tag_shift;
    logic pay_shift;
    logic sel_pay;
  } pbfe_cmd_t;

  typedef struct packed {
    logic drop;
    logic tag_more;
    logic pay_more;
  } pbfe_sts_t;

endpackage

// File: src/pbfe_datapath.sv
// ---------------------------------------------------------------------------
// pbfe_datapath
// Tag and payload shift registers, mode decode and output byte forming.
// ---------------------------------------------------------------------------
module pbfe_datapath (
  input  logic                           clk,
  input  logic [pbfe_pkg::IN_W-1:0]      s_tdata,
  input  pbfe_pkg::pbfe_cmd_t            cmd,
  output pbfe_pkg::pbfe_sts_t            sts,
  output logic [7:0]                     out_byte,
  output logic                           last
);

  logic [pbfe_pkg::FNUM_W-1:0]  fnum_in;
  logic [pbfe_pkg::MODE_W-1:0]  mode_in;
  logic [pbfe_pkg::VALUE_W-1:0] value_in;

  logic [2:0]                   wire_in;
  logic [pbfe_pkg::VALUE_W-1:0] payload_in;
  logic                         fixed_in;
  logic [pbfe_pkg::CNT_W-1:0]   fcnt_in;
  logic [31:0]                  zz32;
  logic                         drop;

  logic [pbfe_pkg::TAG_W-1:0]   tag;
  logic [pbfe_pkg::VALUE_W-1:0] pay;
  logic                         fixed;
  logic [pbfe_pkg::CNT_W-1:0]   fcnt;

  logic tag_more;
  logic pay_more;

  assign fnum_in  = s_tdata[pbfe_pkg::FNUM_W-1:0];
  assign mode_in  = s_tdata[pbfe_pkg::FNUM_W +: pbfe_pkg::MODE_W];
  assign value_in = s_tdata[pbfe_pkg::FNUM_W + pbfe_pkg::MODE_W +: pbfe_pkg::VALUE_W];

  assign zz32 = {value_in[30:0], 1'b0} ^ {32{value_in[31]}};

  // mode decode
  always_comb begin
    wire_in    = pbfe_pkg::WIRE_VARINT;
    payload_in = value_in;
    fixed_in   = 1'b0;
    fcnt_in    = pbfe_pkg::FIXED64_BYTES;
    drop       = 1'b0;
    case (mode_in)
      pbfe_pkg::MODE_VARINT: begin
        payload_in = value_in;
      end
      pbfe_pkg::MODE_ZIGZAG32: begin
        payload_in = {32'd0, zz32};
      end
      pbfe_pkg::MODE_ZIGZAG64: begin
        payload_in = {value_in[62:0], 1'b0} ^ {pbfe_pkg::VALUE_W{value_in[63]}};
      end
      pbfe_pkg::MODE_FIXED32: begin
        wire_in    = pbfe_pkg::WIRE_I32;
        payload_in = {32'd0, value_in[31:0]};
        fixed_in   = 1'b1;
        fcnt_in    = pbfe_pkg::FIXED32_BYTES;
      end
      pbfe_pkg::MODE_FIXED64: begin
        wire_in  = pbfe_pkg::WIRE_I64;
        fixed_in = 1'b1;
        fcnt_in  = pbfe_pkg::FIXED64_BYTES;
      end
      pbfe_pkg::MODE_LENGTH: begin
        wire_in = pbfe_pkg::WIRE_LEN;
        drop    = (value_in == '0);
      end
      default: begin
        drop = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag   <= {fnum_in, wire_in};
      pay   <= payload_in;
      fixed <= fixed_in;
      fcnt  <= fcnt_in;
    end else begin
      if (cmd.tag_shift) begin
        tag <= tag >> 7;
      end
      if (cmd.pay_shift) begin
        if (fixed) begin
          pay  <= pay >> 8;
          fcnt <= fcnt - 1'b1;
        end else begin
          pay <= pay >> 7;
        end
      end
    end
  end

  assign tag_more = (tag[pbfe_pkg::TAG_W-1:7] != '0);
  assign pay_more = fixed ? (fcnt != 4'd1) : (pay[pbfe_pkg::VALUE_W-1:7] != '0);

  assign sts.drop     = drop;
  assign sts.tag_more = tag_more;
  assign sts.pay_more = pay_more;

  always_comb begin
    if (!cmd.sel_pay) begin
      out_byte = {tag_more, tag[6:0]};
    end else if (fixed) begin
      out_byte = pay[7:0];
    end else begin
      out_byte = {pay_more, pay[6:0]};
    end
  end

  assign last = cmd.sel_pay && !pay_more;

endmodule

// File: src/pbfe_ctrl.sv
// ---------------------------------------------------------------------------
// pbfe_ctrl
// Sequencer: accepts a request, walks the tag bytes then the payload bytes.
// ---------------------------------------------------------------------------
module pbfe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  pbfe_pkg::pbfe_sts_t sts,
  output pbfe_pkg::pbfe_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TAG,
    S_PAY
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state != S_IDLE);

  assign cmd.load      = (state == S_IDLE) && s_tvalid && !sts.drop;
  assign cmd.tag_shift = (state == S_TAG) && m_tready && sts.tag_more;
  assign cmd.pay_shift = (state == S_PAY) && m_tready && sts.pay_more;
  assign cmd.sel_pay   = (state == S_PAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && !sts.drop) begin
            state <= S_TAG;
          end
        end
        S_TAG: begin
          if (m_tready && !sts.tag_more) begin
            state <= S_PAY;
          end
        end
        S_PAY: begin
          if (m_tready && !sts.pay_more) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_to_tag: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_TAG)
    else $error("accepted request did not start tag");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.tag_shift, cmd.pay_shift}))
    else $error("conflicting datapath commands");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAY && m_tready && !sts.pay_more) |=> s_tready)
    else $error("final byte did not return to idle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> !s_tready)
    else $error("request taken while output stalled");
`endif

endmodule

// File: src/protobuf_field_encoder_unit.sv
// ---------------------------------------------------------------------------
// protobuf_field_encoder_unit
// Encodes one field per request as tag varint plus value bytes in wire format.
// ---------------------------------------------------------------------------
// channel  dir  tdata                                    tuser  tlast
// s_*      in   fnum[28:0] mode[31:29]                   -      -
//               value[95:32]
// m_*      out  out_byte[7:0]                            -      last
//
// within an item one byte leaves per cycle while m_tready is high; an item is
// accepted in idle and then gives 2 to 15 bytes (up to 5-byte tag, 10-byte varint)
// the tag/payload shift registers hold one item, so s_tready is high only when idle
// modes 6 and 7 and a zero length are accepted in idle and produce nothing
// rst is synchronous and returns the sequencer to idle
// ---------------------------------------------------------------------------
module protobuf_field_encoder_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [pbfe_pkg::IN_W-1:0] s_tdata,   // fnum, mode, value
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // out_byte
  output logic                      m_tlast
);

  pbfe_pkg::pbfe_cmd_t cmd;
  pbfe_pkg::pbfe_sts_t sts;

  pbfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbfe_datapath u_datapath (
    .clk      (clk),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_byte (m_tdata),
    .last     (m_tlast)
  );

endmodule

// File: bench/protobuf_field_encoder_unit_tb.sv
// ---------------------------------------------------------------------------
// protobuf_field_encoder_unit_tb
// Drives field requests (field number, mode, value) into the encoder and
// checks every output byte and its last flag against typed-in bytes or an
// in-bench wire-format encoder. A directed table covers the extremes, all modes,
// the unused modes, zero length and field number zero. Random requests follow,
// with random gaps on the request side and random stalls on the byte side.
// ---------------------------------------------------------------------------
module protobuf_field_encoder_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FNUM_W = pbfe_pkg::FNUM_W;
  localparam int MODE_W = pbfe_pkg::MODE_W;

  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;
  localparam logic [FNUM_W-1:0] FNUM_MAX      = {FNUM_W{1'b1}};
  localparam logic [63:0]       ALL_ONES      = {64{1'b1}};
  localparam logic [63:0]       SIGN_BIT      = 64'h8000_0000_0000_0000;

  localparam int N_DIR       = 23;
  localparam int RAND_FIELDS = 380;
  localparam int TAIL_CYCLES = 40;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  typedef struct {
    logic [FNUM_W-1:0] fnum;
    logic [MODE_W-1:0] mode;
    logic [63:0]       value;
    bit                known;
    int                nbytes;
    logic [63:0]       bytes_le;
  } dir_row_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [pbfe_pkg::IN_W-1:0] s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [7:0]                m_tdata;
  logic                      m_tlast;

  enc_byte_t exp_bytes[$];
  int        n_sent;
  int        n_bytes;
  int        n_errors;
  int        quiet_cycles;
  bit        no_gaps;

  // expected bytes typed in where they follow directly from the wire format
  dir_row_t dir_tab [N_DIR] = '{
    '{29'd1,    pbfe_pkg::MODE_VARINT,   64'd0,         1'b1, 2, 64'h0008},
    '{29'd0,    pbfe_pkg::MODE_VARINT,   64'd1,         1'b1, 2, 64'h0100},
    '{29'd1,    pbfe_pkg::MODE_LENGTH,   64'd0,         1'b1, 0, 64'h0},
    '{29'd1,    MODE_UNUSED_6,           64'd5,         1'b1, 0, 64'h0},
    '{FNUM_MAX, MODE_UNUSED_7,           ALL_ONES,      1'b1, 0, 64'h0},
    '{29'd0,    MODE_UNUSED_6,           64'd0,         1'b1, 0, 64'h0},
    '{29'd1,    pbfe_pkg::MODE_ZIGZAG32, 64'hFFFF_FFFF, 1'b1, 2, 64'h0108},
    '{29'd1,    pbfe_pkg::MODE_ZIGZAG32, 64'd1,         1'b1, 2, 64'h0208},
    '{29'd1,    pbfe_pkg::MODE_ZIGZAG64, ALL_ONES,      1'b1, 2, 64'h0108},
    '{29'd2,    pbfe_pkg::MODE_FIXED32,  64'h1234_5678, 1'b1, 5, 64'h0000_0012_3456_7815},
    '{29'd1,    pbfe_pkg::MODE_LENGTH,   64'd1,         1'b1, 2, 64'h010A},
    '{29'd15,   pbfe_pkg::MODE_VARINT,   64'd127,       1'b1, 2, 64'h7F78},
    '{FNUM_MAX, pbfe_pkg::MODE_VARINT,   ALL_ONES,      1'b0, 0, 64'h0},
    '{FNUM_MAX, pbfe_pkg::MODE_ZIGZAG64, SIGN_BIT,      1'b0, 0, 64'h0},
    '{29'd3,    pbfe_pkg::MODE_ZIGZAG64, ~SIGN_BIT,     1'b0, 0, 64'h0},
    '{FNUM_MAX, pbfe_pkg::MODE_FIXED64,  ALL_ONES,      1'b0, 0, 64'h0},
    '{29'd1,    pbfe_pkg::MODE_FIXED64,  64'd0,         1'b0, 0, 64'h0},
    '{FNUM_MAX, pbfe_pkg::MODE_LENGTH,   ALL_ONES,      1'b0, 0, 64'h0},
    '{29'd7,    pbfe_pkg::MODE_ZIGZAG32, 64'hDEAD_BEEF_8000_0000, 1'b0, 0, 64'h0},
    '{29'd16,   pbfe_pkg::MODE_FIXED32,  64'hFFFF_FFFF_0000_0000, 1'b0, 0, 64'h0},
    '{29'd16,   pbfe_pkg::MODE_VARINT,   64'd128,       1'b0, 0, 64'h0},
    '{FNUM_MAX, pbfe_pkg::MODE_ZIGZAG32, 64'h7FFF_FFFF, 1'b0, 0, 64'h0},
    '{29'h1000_0000, pbfe_pkg::MODE_VARINT, SIGN_BIT,   1'b0, 0, 64'h0}
  };

  protobuf_field_encoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic void push_varint(logic [63:0] v);
    while (v >= 64'h80) begin
      exp_bytes.push_back('{data: {1'b1, v[6:0]}, last: 1'b0});
      v = v >> 7;
    end
    exp_bytes.push_back('{data: v[7:0], last: 1'b0});
  endfunction

  function automatic void push_le(logic [63:0] v, int nb);
    for (int i = 0; i < nb; i++) begin
      exp_bytes.push_back('{data: v[8*i +: 8], last: 1'b0});
    end
  endfunction

  // wire-format encoding of one field, appended to the expected byte stream
  function automatic void encode_field(logic [FNUM_W-1:0] fnum, logic [MODE_W-1:0] mode,
                                       logic [63:0] value);
    logic [2:0]  wtype;
    logic [63:0] payload;
    logic [31:0] z32;
    enc_byte_t   tail;
    wtype = pbfe_pkg::WIRE_VARINT;
    payload = value;
    case (mode)
      pbfe_pkg::MODE_VARINT: begin
        wtype = pbfe_pkg::WIRE_VARINT;
      end
      pbfe_pkg::MODE_ZIGZAG32: begin
        z32 = {value[30:0], 1'b0} ^ {32{value[31]}};
        payload = {32'd0, z32};
      end
      pbfe_pkg::MODE_ZIGZAG64: begin
        payload = {value[62:0], 1'b0} ^ {64{value[63]}};
      end
      pbfe_pkg::MODE_FIXED32: begin
        wtype = pbfe_pkg::WIRE_I32;
        payload = {32'd0, value[31:0]};
      end
      pbfe_pkg::MODE_FIXED64: begin
        wtype = pbfe_pkg::WIRE_I64;
      end
      pbfe_pkg::MODE_LENGTH: begin
        if (value == 64'd0) return;
        wtype = pbfe_pkg::WIRE_LEN;
      end
      default: return;
    endcase
    push_varint({32'd0, fnum, wtype});
    if (mode == pbfe_pkg::MODE_FIXED32) push_le(payload, 4);
    else if (mode == pbfe_pkg::MODE_FIXED64) push_le(payload, 8);
    else push_varint(payload);
    tail = exp_bytes.pop_back();
    tail.last = 1'b1;
    exp_bytes.push_back(tail);
  endfunction

  task automatic flag_mismatch(string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic send_request(logic [FNUM_W-1:0] fnum, logic [MODE_W-1:0] mode,
                              logic [63:0] value, bit known, int nbytes,
                              logic [63:0] bytes_le);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {value, mode, fnum};
    do @(posedge clk); while (!s_tready);
    n_sent++;
    no_gaps = (n_sent % 64) >= 48;
    if (known) begin
      for (int i = 0; i < nbytes; i++) begin
        exp_bytes.push_back('{data: bytes_le[8*i +: 8], last: (i == nbytes - 1)});
      end
    end else begin
      encode_field(fnum, mode, value);
    end
  endtask

  // byte sink with random stalls, compares each accepted byte
  initial begin : byte_sink
    int        stall;
    enc_byte_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      n_bytes++;
      if (exp_bytes.size() == 0) begin
        flag_mismatch($sformatf("byte %02h last %0b with nothing expected", m_tdata, m_tlast));
      end else begin
        want = exp_bytes.pop_front();
        if (m_tdata !== want.data)
          flag_mismatch($sformatf("byte %02h, expected %02h", m_tdata, want.data));
        if (m_tlast !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
      end
    end
  end

  // counts cycles without an accepted request, so a stuck output cannot hold the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no request accepted for %0d cycles", $realtime,
                 quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [FNUM_W-1:0] fnum;
    logic [MODE_W-1:0] mode;
    logic [63:0]       value;
    logic [63:0]       raw;
    int                n_rand;
    n_rand = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      send_request(dir_tab[i].fnum, dir_tab[i].mode, dir_tab[i].value,
                   dir_tab[i].known, dir_tab[i].nbytes, dir_tab[i].bytes_le);
    end

    while (n_rand < RAND_FIELDS) begin
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: fnum = FNUM_W'($urandom_range(1, 15));
        1: fnum = FNUM_W'($urandom_range(16, 2047));
        2: fnum = $urandom_range(0, 7) == 0 ? '0 : FNUM_MAX;
        default: fnum = FNUM_W'($urandom);
      endcase
      if ($urandom_range(0, 31) == 0) begin
        mode = $urandom_range(0, 1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
      end else begin
        mode = MODE_W'($urandom_range(0, 5));
      end
      case ($urandom_range(0, 5))
        0: value = raw >> $urandom_range(0, 63);
        1: value = ~(raw >> $urandom_range(1, 63));
        2: value = 64'($urandom_range(0, 300));
        3: value = $urandom_range(0, 1) ? ALL_ONES : SIGN_BIT;
        default: value = raw;
      endcase
      if (mode == pbfe_pkg::MODE_LENGTH && $urandom_range(0, 15) == 0) value = '0;
      send_request(fnum, mode, value, 1'b0, 0, '0);
      if (mode <= pbfe_pkg::MODE_LENGTH &&
          !(mode == pbfe_pkg::MODE_LENGTH && value == '0)) n_rand++;
    end
    s_tvalid <= 1'b0;

    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d field requests (%0d directed), %0d encoded bytes compared",
             n_sent, N_DIR, n_bytes);
    $display("Summary: %0d errors, %0d bytes still outstanding", n_errors, exp_bytes.size());
    if (n_errors == 0 && exp_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
